[src/lls_pkg.sv]
// package for the link latency statistics block
// state, function codes, constants and divider request and response types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lls_pkg;

  localparam int LLS_SLOTS = 64;

  localparam logic [2:0] FUNC_SEND     = 3'd0;
  localparam logic [2:0] FUNC_REPLY    = 3'd1;
  localparam logic [2:0] FUNC_CALC     = 3'd2;
  localparam logic [2:0] FUNC_RESTART  = 3'd3;
  localparam logic [2:0] FUNC_RETARGET = 3'd4;

  localparam logic [13:0] DROP_MARK    = 14'd9999;
  localparam logic [13:0] FRAME_MAX    = 14'd9998;
  localparam logic [31:0] FRAME_HALF   = 32'd4999;
  localparam logic [31:0] MS_CAP       = 32'd1000;
  localparam logic [31:0] STATS_PERIOD = 32'd1000;
  localparam logic [9:0]  STAT_CAP     = 10'd999;
  localparam logic [6:0]  DEV_CAP      = 7'd99;
  localparam logic [31:0] SPREAD_LIMIT = 32'd2000;
  localparam logic [31:0] MIN_START    = 32'd9999999;
  localparam logic [13:0] PCT_SCALE    = 14'd100;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 8;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } lls_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } lls_div_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RPL_DIV,
    ST_RPL_WAIT,
    ST_CALC,
    ST_W1_RD,
    ST_W1_ACC,
    ST_W1_END,
    ST_AVG_WAIT,
    ST_W2_RD,
    ST_W2_Q,
    ST_W2_MUL,
    ST_W2_ACC,
    ST_V_NS2,
    ST_V_S1S,
    ST_V_D4,
    ST_DV_MUL,
    ST_DV_CMP,
    ST_LOSS_DIV,
    ST_LOSS_WAIT,
    ST_E_RD,
    ST_E_CALC,
    ST_OUT_WAIT
  } lls_state_t;

endpackage
`default_nettype wire

[src/lls_div.sv]
// restoring divider, one quotient bit per cycle
// depends on lls_pkg for widths and request types
`timescale 1ns / 1ps
`default_nettype none
module lls_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lls_pkg::lls_div_req_t req,
  output lls_pkg::lls_div_rsp_t      rsp
);
  import lls_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] div_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, q_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_DW'(trial - {1'b0, div_r}) : DIV_DW'(trial);
        q_r   <= {q_r[DIV_NW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

[src/link_latency_statistics_top.sv]
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tuser func, tdata now_ms, reply_seq, reply_tag
// out     | out | out_tvalid/tready  | tdata result fields, tlast last
// cfg     | in  | cfg_valid/ready    | cfg_data frames_mode
// the reply slot comes from a reciprocal multiply
// calc streams one result word per slot; when stats are due it first walks the
// window, divides once for the mean, walks the window again and runs the deviation
// search on the shared multiplier (an empty window skips all three, too wide a spread the last two)
// reset and restart run a clearing pass over the slot memories
// one item at a time; a stalled output holds the sequencer
`timescale 1ns / 1ps
`default_nettype none
module link_latency_statistics_top #(
  parameter int SLOTS = lls_pkg::LLS_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // func
  input  wire logic [79:0] in_tdata,   // now_ms, reply_seq, reply_tag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // seq_out, accepted, entry_index, entry_latency, loss_percent, min_ms, avg_ms,
  // max_ms, dev_ms, zero pad
  output logic [87:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data    // frames_mode
);
  import lls_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  // reciprocal of SLOTS, exact for dividends below 2^16
  localparam int          RCP_SH = 24;
  localparam logic [24:0] RCP_M  = 25'((2**24 + SLOTS - 1) / SLOTS);
  localparam logic [31:0] LOSS_M = 32'(RCP_M) * 32'(PCT_SCALE);

  lls_state_t state_r, state_nxt;

  logic [31:0] send_mem [SLOTS];
  logic [31:0] recv_mem [SLOTS];
  logic [31:0] lag_mem  [SLOTS];
  logic [31:0] rd_send_r, rd_recv_r, rd_lag_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              send_we, rcv_we, clr_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [31:0]       send_wd, recv_wd, lag_wd;

  logic              frames_mode_r;
  logic [31:0]       out_count_r, in_count_r, session_r, last_stats_r, now_r;
  logic [15:0]       rseq_r;
  logic [15:0]       quo_r;
  logic              forced_r;
  logic [SLOT_W-1:0] out_slot_r, clr_r, k_r, s_r, start_r;
  logic [SLOTS-1:0]  pend_r;
  logic [CNT_W-1:0]  drops_r, cnt_r, wlen_r, n_r;
  logic [31:0]       mn_r, mx_r;
  logic [37:0]       sum_r;
  logic [9:0]        avg_r, min_st_r, avg_st_r, max_st_r;
  logic [6:0]        dev_r, dev_st_r, loss_st_r, d_r;
  logic [16:0]       s1_r;
  logic [27:0]       s2_r;
  logic [10:0]       q_r;
  logic [34:0]       t_r;
  logic [36:0]       d4_r;
  logic [14:0]       u_r;
  logic [55:0]       mul_r;
  logic [27:0]       mul_a, mul_b;
  logic              emit_r;
  logic              out_valid_r, out_last_r;
  logic [87:0]       out_data_r;

  lls_div_req_t div_req;
  lls_div_rsp_t div_rsp;

  logic        in_acc;
  logic [2:0]  in_func;
  logic [31:0] in_now, in_tag;
  logic [15:0] in_seq;
  logic        reply_ok;
  logic [31:0] diff, p_w, lo_w, hi_w;
  logic        due;
  logic [13:0] ent_lat;
  logic [SLOT_W-1:0] rpl_k;

  function automatic logic [SLOT_W-1:0] nxt_slot(input logic [SLOT_W-1:0] k);
    return (k == LAST_SLOT) ? '0 : k + 1'b1;
  endfunction

  function automatic logic [9:0] cap_stat(input logic [39:0] v);
    return (v > 40'(STAT_CAP)) ? STAT_CAP : v[9:0];
  endfunction

  lls_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_func = in_tuser;
  assign in_now  = in_tdata[31:0];
  assign in_seq  = in_tdata[47:32];
  assign in_tag  = in_tdata[79:48];
  assign in_acc  = in_tvalid && in_tready;
  assign reply_ok = (in_tag == session_r) && (32'(in_seq) > in_count_r);
  assign rpl_k    = SLOT_W'(rseq_r - 16'(quo_r * 16'(SLOTS)));

  assign diff = rd_recv_r - rd_send_r;
  assign p_w  = diff[31] ? 32'd0 : diff;
  assign lo_w = (out_count_r >= 32'(SLOTS)) ? out_count_r - 32'(SLOTS) : 32'd0;
  assign hi_w = (in_count_r < out_count_r) ? in_count_r : out_count_r;
  assign due  = forced_r || ((now_r - last_stats_r) > STATS_PERIOD);

  always_comb begin
    if (pend_r[s_r]) begin
      ent_lat = DROP_MARK;
    end else if (frames_mode_r) begin
      if (rd_lag_r[31]) ent_lat = '0;
      else if (rd_lag_r >= FRAME_HALF) ent_lat = FRAME_MAX;
      else ent_lat = {rd_lag_r[12:0], 1'b0};
    end else begin
      ent_lat = (p_w > MS_CAP) ? MS_CAP[13:0] : p_w[13:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == LAST_SLOT) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_SEND:     state_nxt = ST_OUT_WAIT;
            FUNC_REPLY:    state_nxt = reply_ok ? ST_RPL_DIV : ST_OUT_WAIT;
            FUNC_CALC:     state_nxt = ST_CALC;
            FUNC_RESTART:  state_nxt = ST_CLEAR;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RPL_DIV:   state_nxt = ST_RPL_WAIT;
      ST_RPL_WAIT:  state_nxt = ST_OUT_WAIT;
      ST_CALC:      state_nxt = due ? ST_W1_RD : ST_E_RD;
      ST_W1_RD:     state_nxt = (cnt_r == '0) ? ST_W1_END : ST_W1_ACC;
      ST_W1_ACC:    state_nxt = ST_W1_RD;
      ST_W1_END:    state_nxt = (n_r == '0) ? ST_LOSS_DIV : ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ((mx_r - mn_r) > SPREAD_LIMIT) ? ST_LOSS_DIV : ST_W2_RD;
        end
      end
      ST_W2_RD:     state_nxt = (cnt_r == '0) ? ST_V_NS2 : ST_W2_Q;
      ST_W2_Q:      state_nxt = pend_r[k_r] ? ST_W2_RD : ST_W2_MUL;
      ST_W2_MUL:    state_nxt = ST_W2_ACC;
      ST_W2_ACC:    state_nxt = ST_W2_RD;
      ST_V_NS2:     state_nxt = ST_V_S1S;
      ST_V_S1S:     state_nxt = ST_V_D4;
      ST_V_D4:      state_nxt = ST_DV_MUL;
      ST_DV_MUL:    state_nxt = ST_DV_CMP;
      ST_DV_CMP: begin
        if (mul_r[36:0] <= d4_r && d_r != DEV_CAP) state_nxt = ST_DV_MUL;
        else state_nxt = ST_LOSS_DIV;
      end
      ST_LOSS_DIV:  state_nxt = ST_LOSS_WAIT;
      ST_LOSS_WAIT: state_nxt = ST_E_RD;
      ST_E_RD:      state_nxt = ST_E_CALC;
      ST_E_CALC:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_tready) state_nxt = (emit_r && s_r != LAST_SLOT) ? ST_E_RD : ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    rd_addr   = (state_r == ST_E_RD) ? s_r : k_r;
    clr_we    = (state_r == ST_CLEAR);
    send_we   = clr_we || (in_acc && in_func == FUNC_SEND);
    rcv_we    = clr_we || (state_r == ST_RPL_WAIT);
    wr_addr   = clr_we ? clr_r : (state_r == ST_RPL_WAIT) ? rpl_k : out_slot_r;
    send_wd   = clr_we ? 32'd0 : in_now;
    recv_wd   = clr_we ? 32'd0 : now_r;
    lag_wd    = clr_we ? 32'd0 : out_count_r - 32'(rseq_r);
    mul_a     = 28'(q_r);
    mul_b     = 28'(q_r);
    case (state_r)
      ST_V_NS2:  begin mul_a = 28'(n_r);  mul_b = s2_r;       end
      ST_V_S1S:  begin mul_a = 28'(s1_r); mul_b = 28'(s1_r);  end
      ST_DV_MUL: begin mul_a = 28'(u_r);  mul_b = 28'(u_r);   end
      default:   ;
    endcase
    // the divider only forms the rounded mean
    div_req.start    = (state_r == ST_W1_END) && (n_r != '0);
    div_req.dividend = 40'({sum_r, 1'b0}) + 40'(n_r);
    div_req.divisor  = DIV_DW'({n_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (send_we) send_mem[wr_addr] <= send_wd;
    if (rcv_we) begin
      recv_mem[wr_addr] <= recv_wd;
      lag_mem[wr_addr]  <= lag_wd;
    end
    rd_send_r <= send_mem[rd_addr];
    rd_recv_r <= recv_mem[rd_addr];
    rd_lag_r  <= lag_mem[rd_addr];
    mul_r     <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      frames_mode_r <= 1'b0;
      out_count_r   <= '0;
      in_count_r    <= '0;
      session_r     <= '0;
      last_stats_r  <= '0;
      forced_r      <= 1'b1;
      out_slot_r    <= '0;
      clr_r         <= '0;
      pend_r        <= '0;
      drops_r       <= '0;
      min_st_r      <= '0;
      avg_st_r      <= '0;
      max_st_r      <= '0;
      dev_st_r      <= '0;
      loss_st_r     <= '0;
      emit_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      s_r           <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) frames_mode_r <= cfg_data[0];
      case (state_r)
        ST_CLEAR: clr_r <= nxt_slot(clr_r);
        ST_IDLE: begin
          if (in_acc) begin
            now_r  <= in_now;
            rseq_r <= in_seq;
            out_data_r <= '0;
            out_last_r <= 1'b1;
            emit_r     <= 1'b0;
            case (in_func)
              FUNC_SEND: begin
                pend_r[out_slot_r] <= 1'b1;
                if (!pend_r[out_slot_r]) drops_r <= drops_r + 1'b1;
                out_data_r[15:0] <= out_count_r[15:0];
                out_valid_r <= 1'b1;
                out_count_r <= out_count_r + 1'b1;
                out_slot_r  <= nxt_slot(out_slot_r);
              end
              FUNC_REPLY: out_valid_r <= !reply_ok;
              FUNC_RESTART: begin
                pend_r      <= '0;
                drops_r     <= '0;
                out_count_r <= '0;
                in_count_r  <= '0;
                out_slot_r  <= '0;
                clr_r       <= '0;
                forced_r    <= 1'b1;
                session_r   <= in_now;
              end
              FUNC_RETARGET: begin
                in_count_r <= out_count_r;
                forced_r   <= 1'b1;
                session_r  <= in_now;
              end
              default: ;
            endcase
          end
        end
        ST_RPL_DIV: quo_r <= 16'((41'(rseq_r) * 41'(RCP_M)) >> RCP_SH);
        ST_RPL_WAIT: begin
          pend_r[rpl_k] <= 1'b0;
          if (pend_r[rpl_k]) drops_r <= drops_r - 1'b1;
          in_count_r     <= 32'(rseq_r);
          out_data_r[16] <= 1'b1;
          out_valid_r    <= 1'b1;
        end
        ST_CALC: begin
          emit_r  <= 1'b1;
          s_r     <= '0;
          start_r <= (out_count_r >= 32'(SLOTS)) ? out_slot_r : '0;
          k_r     <= (out_count_r >= 32'(SLOTS)) ? out_slot_r : '0;
          wlen_r  <= (hi_w > lo_w) ? CNT_W'(hi_w - lo_w) : '0;
          cnt_r   <= (hi_w > lo_w) ? CNT_W'(hi_w - lo_w) : '0;
          mn_r    <= MIN_START;
          mx_r    <= '0;
          sum_r   <= '0;
          n_r     <= '0;
          if (due) begin
            last_stats_r <= now_r;
            forced_r     <= 1'b0;
          end
        end
        ST_W1_ACC: begin
          if (!pend_r[k_r]) begin
            if (p_w < mn_r) mn_r <= p_w;
            if (p_w > mx_r) mx_r <= p_w;
            sum_r <= sum_r + 38'(p_w);
            n_r   <= n_r + 1'b1;
          end
          k_r   <= nxt_slot(k_r);
          cnt_r <= cnt_r - 1'b1;
        end
        ST_W1_END: begin
          if (n_r == '0) begin
            mn_r  <= '0;
            mx_r  <= '0;
            avg_r <= '0;
            dev_r <= '0;
          end
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg_r <= cap_stat(div_rsp.quot);
            dev_r <= DEV_CAP;
            k_r   <= start_r;
            cnt_r <= wlen_r;
            s1_r  <= '0;
            s2_r  <= '0;
          end
        end
        ST_W2_Q: begin
          q_r <= 11'(p_w - mn_r);
          if (pend_r[k_r]) begin
            k_r   <= nxt_slot(k_r);
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_W2_ACC: begin
          s1_r  <= s1_r + 17'(q_r);
          s2_r  <= s2_r + mul_r[27:0];
          k_r   <= nxt_slot(k_r);
          cnt_r <= cnt_r - 1'b1;
        end
        ST_V_S1S: t_r <= mul_r[34:0];
        ST_V_D4: begin
          d4_r  <= {t_r - mul_r[34:0], 2'b00};
          d_r   <= 7'd1;
          u_r   <= 15'(n_r);
          dev_r <= '0;
        end
        ST_DV_CMP: begin
          // largest d up to DEV_CAP with (2d-1)^2 n^2 <= 4 (n s2 - s1^2)
          if (mul_r[36:0] <= d4_r) begin
            dev_r <= d_r;
            d_r   <= d_r + 1'b1;
            u_r   <= u_r + 15'({n_r, 1'b0});
          end
        end
        ST_LOSS_DIV: quo_r <= 16'((40'(drops_r) * 40'(LOSS_M)) >> RCP_SH);
        ST_LOSS_WAIT: begin
          loss_st_r <= 7'(quo_r);
          min_st_r  <= cap_stat(40'(mn_r));
          avg_st_r  <= avg_r;
          max_st_r  <= cap_stat(40'(mx_r));
          dev_st_r  <= dev_r;
        end
        ST_E_CALC: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (s_r == LAST_SLOT);
          out_data_r  <= {7'd0, dev_st_r, max_st_r, avg_st_r, min_st_r, loss_st_r,
                          ent_lat, 6'(s_r), 1'b0, 16'd0};
        end
        ST_OUT_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (emit_r && s_r != LAST_SLOT) s_r <= s_r + 1'b1;
            else emit_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_r) == int'(drops_r))
    else $error("drop counter out of step with pending marks");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while a result word waits");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_RPL_WAIT || state_r == ST_AVG_WAIT ||
                      state_r == ST_LOSS_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

[tb/link_latency_statistics_top_tb.sv]
// testbench for link_latency_statistics_top: directed and random probe traffic,
// checked word by word against a behavioral predictor; needs lls_pkg and the top
`timescale 1ns / 1ps
module link_latency_statistics_top_tb;
  import lls_pkg::*;

  localparam int NSLOT = LLS_SLOTS;

  typedef struct {
    logic [15:0] seq_out;
    logic        accepted;
    logic [5:0]  entry_index;
    logic [13:0] entry_latency;
    logic [6:0]  loss_percent;
    logic [9:0]  min_ms;
    logic [9:0]  avg_ms;
    logic [9:0]  max_ms;
    logic [6:0]  dev_ms;
    logic        last;
  } probe_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  link_latency_statistics_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] p_send[NSLOT];
  logic [31:0] p_recv[NSLOT];
  logic        p_pend[NSLOT];
  logic [31:0] p_lag[NSLOT];
  logic [13:0] p_table[NSLOT];
  logic [31:0] p_out_cnt, p_in_cnt, p_tag, p_last_ms;
  logic        p_forced, p_frames;
  logic [9:0]  p_min, p_avg, p_max;
  logic [6:0]  p_dev, p_loss;

  probe_result_t expected_q[$];
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [31:0] clock_ms = 0;

  function automatic logic [31:0] ping_of(int k);
    logic [31:0] d;
    d = p_recv[k] - p_send[k];
    return d[31] ? 32'd0 : d;
  endfunction

  function automatic void clear_probes();
    for (int k = 0; k < NSLOT; k++) begin
      p_send[k] = 0; p_recv[k] = 0; p_pend[k] = 0; p_lag[k] = 0; p_table[k] = 0;
    end
  endfunction

  function automatic void rebuild_latency();
    logic [31:0] v;
    for (int k = 0; k < NSLOT; k++) begin
      if (p_pend[k]) v = DROP_MARK;
      else if (p_frames) begin
        if (p_lag[k][31]) v = 0;
        else if (p_lag[k] >= FRAME_HALF) v = FRAME_MAX;
        else v = 2 * p_lag[k];
      end else begin
        v = ping_of(k);
        if (v > MS_CAP) v = MS_CAP;
      end
      p_table[k] = v[13:0];
    end
  endfunction

  function automatic void recompute_ping_stats();
    logic [31:0] lo, hi, mn, mx, p, n, drops;
    longint unsigned sum, avg, s1, s2, q, d4, nn, t;
    int dv;
    lo = (p_out_cnt >= NSLOT) ? p_out_cnt - NSLOT : 0;
    hi = (p_in_cnt < p_out_cnt) ? p_in_cnt : p_out_cnt;
    n = 0; mn = MIN_START; mx = 0; sum = 0; drops = 0;
    for (logic [31:0] i = lo; i < hi; i++) begin
      if (!p_pend[i % NSLOT]) begin
        p = ping_of(i % NSLOT);
        if (p < mn) mn = p;
        if (p > mx) mx = p;
        sum += p;
        n++;
      end
    end
    if (n > 0) begin
      avg = (2 * sum + n) / (2 * longint'(n));
      dv = 0;
      if (mx - mn > SPREAD_LIMIT) dv = DEV_CAP;
      else begin
        s1 = 0; s2 = 0;
        for (logic [31:0] i = lo; i < hi; i++) begin
          if (!p_pend[i % NSLOT]) begin
            q = ping_of(i % NSLOT) - mn;
            s1 += q;
            s2 += q * q;
          end
        end
        nn = longint'(n) * n;
        d4 = 4 * (longint'(n) * s2 - s1 * s1);
        for (int d = 1; d <= DEV_CAP; d++) begin
          t = 2 * d - 1;
          if (t * t * nn <= d4) dv = d;
        end
      end
      p_min = (mn > STAT_CAP) ? STAT_CAP : mn[9:0];
      p_avg = (avg > STAT_CAP) ? STAT_CAP : avg[9:0];
      p_max = (mx > STAT_CAP) ? STAT_CAP : mx[9:0];
      p_dev = dv[6:0];
    end else begin
      p_min = 0; p_avg = 0; p_max = 0; p_dev = 0;
    end
    for (int k = 0; k < NSLOT; k++) if (p_table[k] == DROP_MARK) drops++;
    p_loss = (drops * 100) / NSLOT;
  endfunction

  function automatic void predict_probe(logic [2:0] func, logic [31:0] now,
                                        logic [15:0] rseq, logic [31:0] rtag);
    probe_result_t r;
    int k;
    r = '{default: '0};
    case (func)
      FUNC_SEND: begin
        k = p_out_cnt % NSLOT;
        p_send[k] = now; p_pend[k] = 1;
        r.seq_out = p_out_cnt[15:0];
        r.last = 1;
        p_out_cnt++;
        expected_q.push_back(r);
      end
      FUNC_REPLY: begin
        r.accepted = (rtag == p_tag) && ({16'd0, rseq} > p_in_cnt);
        if (r.accepted) begin
          k = rseq % NSLOT;
          p_recv[k] = now; p_pend[k] = 0;
          p_lag[k] = p_out_cnt - rseq;
          p_in_cnt = rseq;
        end
        r.last = 1;
        expected_q.push_back(r);
      end
      FUNC_CALC: begin
        rebuild_latency();
        if (p_forced || (now - p_last_ms) > STATS_PERIOD) begin
          p_last_ms = now; p_forced = 0;
          recompute_ping_stats();
        end
        for (int s = 0; s < NSLOT; s++) begin
          r.entry_index = s; r.entry_latency = p_table[s];
          r.loss_percent = p_loss; r.min_ms = p_min; r.avg_ms = p_avg;
          r.max_ms = p_max; r.dev_ms = p_dev; r.last = (s == NSLOT - 1);
          expected_q.push_back(r);
        end
      end
      FUNC_RESTART: begin
        clear_probes();
        p_out_cnt = 0; p_in_cnt = 0; p_forced = 1; p_tag = now;
      end
      FUNC_RETARGET: begin
        p_in_cnt = p_out_cnt; p_forced = 1; p_tag = now;
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fail_cnt++;
      end else begin
        probe_result_t e;
        e = expected_q.pop_front();
        if (out_tdata[15:0] !== e.seq_out) begin
          $error("seq_out exp %0d got %0d", e.seq_out, out_tdata[15:0]); fail_cnt++;
        end
        if (out_tdata[16] !== e.accepted) begin
          $error("accepted exp %0d got %0d", e.accepted, out_tdata[16]); fail_cnt++;
        end
        if (out_tdata[22:17] !== e.entry_index) begin
          $error("entry_index exp %0d got %0d", e.entry_index, out_tdata[22:17]);
          fail_cnt++;
        end
        if (out_tdata[36:23] !== e.entry_latency) begin
          $error("entry_latency exp %0d got %0d", e.entry_latency, out_tdata[36:23]);
          fail_cnt++;
        end
        if (out_tdata[43:37] !== e.loss_percent) begin
          $error("loss_percent exp %0d got %0d", e.loss_percent, out_tdata[43:37]);
          fail_cnt++;
        end
        if (out_tdata[53:44] !== e.min_ms) begin
          $error("min_ms exp %0d got %0d", e.min_ms, out_tdata[53:44]); fail_cnt++;
        end
        if (out_tdata[63:54] !== e.avg_ms) begin
          $error("avg_ms exp %0d got %0d", e.avg_ms, out_tdata[63:54]); fail_cnt++;
        end
        if (out_tdata[73:64] !== e.max_ms) begin
          $error("max_ms exp %0d got %0d", e.max_ms, out_tdata[73:64]); fail_cnt++;
        end
        if (out_tdata[80:74] !== e.dev_ms) begin
          $error("dev_ms exp %0d got %0d", e.dev_ms, out_tdata[80:74]); fail_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_tlast); fail_cnt++;
        end
      end
    end
  end

  task automatic send_probe(logic [2:0] func, logic [31:0] now,
                            logic [15:0] rseq, logic [31:0] rtag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {rtag, rseq, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_probe(func, now, rseq, rtag);
  endtask

  // drain results, let restart clearing finish, then write frames_mode
  task automatic write_frames_mode(logic mode);
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    p_frames = mode;
  endtask

  task automatic test_directed();
    send_probe(FUNC_CALC, 32'd0, 16'd0, 32'd0);           // empty window
    send_probe(FUNC_SEND, 32'd0, 16'd0, 32'd0);
    send_probe(FUNC_SEND, 32'd10, 16'd0, 32'd0);
    send_probe(FUNC_REPLY, 32'd40, 16'd1, 32'd0);
    send_probe(FUNC_REPLY, 32'd41, 16'd1, 32'd0);          // not newer
    send_probe(FUNC_REPLY, 32'd42, 16'd2, 32'hFFFF_FFFF);  // wrong tag
    send_probe(FUNC_REPLY, 32'd45, 16'hFFFF, 32'd0);       // unsent sequence
    send_probe(FUNC_CALC, 32'd50, 16'd0, 32'd0);           // stats not due
    send_probe(FUNC_CALC, 32'd2000, 16'd0, 32'd0);
    send_probe(FUNC_RESTART, 32'hFFFF_FFFF, 16'd0, 32'd0);
    send_probe(FUNC_SEND, 32'hFFFF_FF00, 16'd0, 32'd0);
    send_probe(FUNC_SEND, 32'hFFFF_FF10, 16'd0, 32'd0);
    send_probe(FUNC_SEND, 32'd100, 16'd0, 32'd0);
    send_probe(FUNC_REPLY, 32'd4000, 16'd1, 32'hFFFF_FFFF); // long ping, wraps
    send_probe(FUNC_REPLY, 32'hFFFF_FF00, 16'd2, 32'hFFFF_FFFF); // negative
    send_probe(5, 32'd1, 16'd1, 32'd1);
    send_probe(6, 32'd1, 16'd1, 32'd1);
    send_probe(7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_probe(FUNC_CALC, 32'd5000, 16'd0, 32'd0);          // one long ping in the window
    send_probe(FUNC_RETARGET, 32'h1234_5678, 16'd0, 32'd0);
    send_probe(FUNC_CALC, 32'd5001, 16'd0, 32'd0);
    clock_ms = 32'd6000;
  endtask

  task automatic test_random(int n, int spct, int rpct, bit hold_mid);
    int sel;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        in_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
      end
      clock_ms += $urandom_range(30);
      if ($urandom_range(19) == 0) clock_ms += $urandom_range(3000);
      sel = $urandom_range(99);
      if (sel < 38) send_probe(FUNC_SEND, clock_ms, $urandom, $urandom);
      else if (sel < 72)
        send_probe(FUNC_REPLY, clock_ms, p_in_cnt + $urandom_range(3, 1), p_tag);
      else if (sel < 84) send_probe(FUNC_CALC, clock_ms, $urandom, $urandom);
      else if (sel < 87) begin
        clock_ms = $urandom;
        send_probe(FUNC_RESTART, clock_ms, $urandom, $urandom);
      end else if (sel < 89)
        send_probe(FUNC_RETARGET, clock_ms, $urandom, $urandom);
      else if (sel < 92) send_probe($urandom_range(7, 5), $urandom, $urandom, $urandom);
      else if (sel < 96) send_probe(FUNC_REPLY, $urandom, $urandom, $urandom);
      else send_probe(FUNC_REPLY, clock_ms, $urandom, p_tag);
    end
  endtask

  initial begin
    clear_probes();
    p_out_cnt = 0; p_in_cnt = 0; p_tag = 0; p_last_ms = 0; p_forced = 1;
    p_frames = 0; p_min = 0; p_avg = 0; p_max = 0; p_dev = 0; p_loss = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_frames_mode(1'b1);
    test_directed();
    test_random(80, 0, 0, 1'b0);
    write_frames_mode(1'b0);
    test_random(80, 47, 0, 1'b1);
    write_frames_mode(1'b1);
    test_random(80, 0, 47, 1'b0);
    write_frames_mode(1'b0);
    test_random(80, 14, 14, 1'b0);
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0) $display("link_latency_statistics_top_tb OK");
    else $display("link_latency_statistics_top_tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("link_latency_statistics_top_tb NOT OK");
    $finish;
  end

endmodule
